// File: rtl/scpr_pkg.sv
// shared types and constants for the second-chance page replacement block
// no dependencies; the top module imports this package and the memories take their depth defaults from it
`timescale 1ns / 1ps

package scpr_pkg;

   // fixed field widths of the request, response and csr channels
   localparam int CFG_W          = 5;
   localparam int PAGE_FIELD_W   = 7;
   localparam int FRAME_FIELD_W  = 4;
   localparam int COUNT_W        = 32;

   // default geometry
   localparam int DEFAULT_FRAMES = 16;
   localparam int DEFAULT_PAGES  = 128;

   // frame_count after reset
   localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = 5'd16;

   // one page reference
   typedef struct packed {
      logic [PAGE_FIELD_W-1:0] page;
      logic                    ref_bit;
   } req_type;

   // one reference result
   typedef struct packed {
      logic                     hit;
      logic [FRAME_FIELD_W-1:0] frame;
      logic                     evicted_valid;
      logic [PAGE_FIELD_W-1:0]  evicted_page;
      logic [COUNT_W-1:0]       hit_total;
      logic [COUNT_W-1:0]       miss_total;
   } rsp_type;

endpackage

// File: rtl/second_chance_page_replacement_top.sv
// a request is taken in idle and looked up; a hit or a fill then goes to the response register
// once that is free, while an eviction first sweeps n = 1 .. frame_count + 1 frames from the
// hand at one per cycle and then places the page; one request is handled at a time, and a new
// one is taken only once the last is in the response register, which frees the input
// reset: synchronous; afterwards the status table is cleared one page per cycle,
// all PAGES entries, with requests stalled (csr writes are taken throughout)
`timescale 1ns / 1ps

module second_chance_page_replacement_top #(
   parameter int FRAMES = scpr_pkg::DEFAULT_FRAMES,
   parameter int PAGES  = scpr_pkg::DEFAULT_PAGES
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  scpr_pkg::req_type               req_data,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output scpr_pkg::rsp_type               rsp_data,
   // frame_count register write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [scpr_pkg::CFG_W-1:0]      csr_data
);

   import scpr_pkg::*;

   localparam int FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int FCNT_W    = $clog2(FRAMES + 1);
   localparam int PAGE_W    = $clog2(PAGES);
   localparam int ST_W      = 1 + FRAME_W;
   localparam int FE_W      = PAGE_W + 1;
   localparam int MOD_DEPTH = 2 ** PAGE_FIELD_W;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK,
      S_SWEEP,
      S_PLACE,
      S_EMIT
   } state_type;

   // page number folded into the table range
   function automatic logic [MOD_DEPTH-1:0][PAGE_W-1:0] build_mod_tbl();
      logic [MOD_DEPTH-1:0][PAGE_W-1:0] t;
      for (int i = 0; i < MOD_DEPTH; i++) begin
         t[i] = PAGE_W'(i % PAGES);
      end
      return t;
   endfunction

   localparam logic [MOD_DEPTH-1:0][PAGE_W-1:0] MOD_TBL = build_mod_tbl();

   // next frame on the clock, wrapping at the frame count
   function automatic logic [FRAME_W-1:0] wrap_inc(input logic [FRAME_W-1:0] a,
                                                   input logic [FCNT_W-1:0]  n);
      logic [FCNT_W-1:0] a_plus;
      a_plus = FCNT_W'(a) + FCNT_W'(1);
      return (a_plus == n) ? '0 : FRAME_W'(a_plus);
   endfunction

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == '1) ? v : v + COUNT_W'(1);
   endfunction

   // registers
   state_type          state_ff,     state_in;
   logic [PAGE_W-1:0]  clr_ff,       clr_in;
   logic [PAGE_W-1:0]  page_ff,      page_in;
   logic               rb_ff,        rb_in;
   logic [FCNT_W-1:0]  fc_ff,        fc_in;
   logic [FCNT_W-1:0]  fill_ff,      fill_in;
   logic [FRAME_W-1:0] hand_ff,      hand_in;
   logic [FRAME_W-1:0] addr_ff,      addr_in;
   logic               fwd_ff,       fwd_in;
   logic [COUNT_W-1:0] hit_cnt_ff,   hit_cnt_in;
   logic [COUNT_W-1:0] miss_cnt_ff,  miss_cnt_in;
   logic               res_hit_ff,   res_hit_in;
   logic [FRAME_W-1:0] res_frame_ff, res_frame_in;
   logic               res_ev_ff,    res_ev_in;
   logic [PAGE_W-1:0]  res_evp_ff,   res_evp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff,  rsp_data_in;
   logic [CFG_W-1:0]   fcount_ff,    fcount_in;

   // memory ports
   logic               st_en, st_we;
   logic [PAGE_W-1:0]  st_addr;
   logic [ST_W-1:0]    st_wdata, st_rdata;
   logic               fr_we, fr_re;
   logic [FRAME_W-1:0] fr_waddr, fr_raddr;
   logic [FE_W-1:0]    fr_wdata, fr_rdata;

   logic [PAGE_W-1:0]  page_mod;
   logic [FCNT_W-1:0]  eff_fc;
   logic               out_free;
   logic               sweep_bit;
   logic [FRAME_W-1:0] sweep_next;
   logic [FRAME_W-1:0] hand_start;

   scpr_status_ram #(
      .DEPTH  (PAGES),
      .DATA_W (ST_W)
   ) u_status (
      .clock (clock),
      .en    (st_en),
      .we    (st_we),
      .addr  (st_addr),
      .wdata (st_wdata),
      .rdata (st_rdata)
   );

   scpr_frame_ram #(
      .DEPTH  (FRAMES),
      .DATA_W (FE_W)
   ) u_frames (
      .clock (clock),
      .we    (fr_we),
      .waddr (fr_waddr),
      .wdata (fr_wdata),
      .re    (fr_re),
      .raddr (fr_raddr),
      .rdata (fr_rdata)
   );

   // effective frame count: zero acts as one, large values clamp to FRAMES
   always_comb begin
      if (fcount_ff == '0) begin
         eff_fc = FCNT_W'(1);
      end else if (32'(fcount_ff) > FRAMES) begin
         eff_fc = FCNT_W'(FRAMES);
      end else begin
         eff_fc = FCNT_W'(fcount_ff);
      end
   end

   assign page_mod   = MOD_TBL[req_data.page];
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign sweep_bit  = fr_rdata[0] && !fwd_ff;
   assign sweep_next = wrap_inc(addr_ff, fc_ff);
   assign hand_start = (FCNT_W'(hand_ff) < fc_ff) ? hand_ff : '0;

   // csr port
   assign csr_ready = 1'b1;
   assign fcount_in = (csr_valid && csr_ready) ? csr_data : fcount_ff;

   // sequencer: lookup, fill, clock sweep, placement and response
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      page_in      = page_ff;
      rb_in        = rb_ff;
      fc_in        = fc_ff;
      fill_in      = fill_ff;
      hand_in      = hand_ff;
      addr_in      = addr_ff;
      fwd_in       = 1'b0;
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      res_hit_in   = res_hit_ff;
      res_frame_in = res_frame_ff;
      res_ev_in    = res_ev_ff;
      res_evp_in   = res_evp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      st_en    = 1'b0;
      st_we    = 1'b0;
      st_addr  = page_ff;
      st_wdata = '0;
      fr_we    = 1'b0;
      fr_waddr = addr_ff;
      fr_wdata = '0;
      fr_re    = 1'b0;
      fr_raddr = addr_ff;

      case (state_ff)
         S_CLEAR: begin
            st_en   = 1'b1;
            st_we   = 1'b1;
            st_addr = clr_ff;
            if (clr_ff == PAGE_W'(PAGES - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + PAGE_W'(1);
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               page_in  = page_mod;
               rb_in    = req_data.ref_bit;
               fc_in    = eff_fc;
               st_en    = 1'b1;
               st_addr  = page_mod;
               state_in = S_LOOK;
            end
         end

         S_LOOK: begin
            res_ev_in  = 1'b0;
            res_evp_in = '0;
            if (st_rdata[ST_W-1]) begin
               // resident page
               hit_cnt_in   = sat_inc(hit_cnt_ff);
               res_hit_in   = 1'b1;
               res_frame_in = st_rdata[FRAME_W-1:0];
               state_in     = S_EMIT;
            end else begin
               miss_cnt_in = sat_inc(miss_cnt_ff);
               res_hit_in  = 1'b0;
               if (fill_ff < fc_ff) begin
                  // free frame: place with bit clear
                  fr_we        = 1'b1;
                  fr_waddr     = FRAME_W'(fill_ff);
                  fr_wdata     = {page_ff, 1'b0};
                  st_en        = 1'b1;
                  st_we        = 1'b1;
                  st_wdata     = {1'b1, FRAME_W'(fill_ff)};
                  res_frame_in = FRAME_W'(fill_ff);
                  fill_in      = fill_ff + FCNT_W'(1);
                  hand_in      = wrap_inc(FRAME_W'(fill_ff), fc_ff);
                  state_in     = S_EMIT;
               end else begin
                  // start the sweep at the hand
                  fr_re    = 1'b1;
                  fr_raddr = hand_start;
                  addr_in  = hand_start;
                  state_in = S_SWEEP;
               end
            end
         end

         S_SWEEP: begin
            if (sweep_bit) begin
               // second chance: clear the bit and move on
               fr_we    = 1'b1;
               fr_waddr = addr_ff;
               fr_wdata = {fr_rdata[FE_W-1:1], 1'b0};
               fr_re    = 1'b1;
               fr_raddr = sweep_next;
               addr_in  = sweep_next;
               fwd_in   = (sweep_next == addr_ff);
            end else begin
               // victim found: new page takes the frame, old page goes absent
               fr_we        = 1'b1;
               fr_waddr     = addr_ff;
               fr_wdata     = {page_ff, rb_ff};
               st_en        = 1'b1;
               st_we        = 1'b1;
               st_addr      = fr_rdata[FE_W-1:1];
               st_wdata     = '0;
               res_ev_in    = 1'b1;
               res_evp_in   = fr_rdata[FE_W-1:1];
               res_frame_in = addr_ff;
               hand_in      = sweep_next;
               state_in     = S_PLACE;
            end
         end

         S_PLACE: begin
            st_en    = 1'b1;
            st_we    = 1'b1;
            st_addr  = page_ff;
            st_wdata = {1'b1, addr_ff};
            state_in = S_EMIT;
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.hit             = res_hit_ff;
               rsp_data_in.frame           = FRAME_FIELD_W'(res_frame_ff);
               rsp_data_in.evicted_valid   = res_ev_ff;
               rsp_data_in.evicted_page    = PAGE_FIELD_W'(res_evp_ff);
               rsp_data_in.hit_total       = hit_cnt_ff;
               rsp_data_in.miss_total      = miss_cnt_ff;
               state_in                    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         fill_ff      <= '0;
         hand_ff      <= '0;
         fwd_ff       <= 1'b0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         fcount_ff    <= FRAME_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fill_ff      <= fill_in;
         hand_ff      <= hand_in;
         fwd_ff       <= fwd_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         fcount_ff    <= fcount_in;
      end
      page_ff      <= page_in;
      rb_ff        <= rb_in;
      fc_ff        <= fc_in;
      addr_ff      <= addr_in;
      res_hit_ff   <= res_hit_in;
      res_frame_ff <= res_frame_in;
      res_ev_ff    <= res_ev_in;
      res_evp_ff   <= res_evp_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // fill level never passes the table size
   assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= FRAMES)
      else $error("fill level beyond frame table");

   // a hit never evicts, and a response without an eviction carries no page number
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.hit |-> !rsp_data_ff.evicted_valid)
      else $error("hit response reports an eviction");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.evicted_valid |-> rsp_data_ff.evicted_page == '0)
      else $error("evicted page set without eviction");

   // the sweep reads back the frame it just wrote only on a single-frame clock
   assert property (@(posedge clock) disable iff (reset)
      fr_we && fr_re && (fr_waddr == fr_raddr) |-> fc_ff == FCNT_W'(1))
      else $error("frame table read and write collide");

   // counters only move upward
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (hit_cnt_ff >= $past(hit_cnt_ff))
                        && (miss_cnt_ff >= $past(miss_cnt_ff)))
      else $error("hit or miss count went backward");

endmodule

// File: rtl/scpr_status_ram.sv
// per-page status memory: resident flag and frame index for each page
// single port, registered read data; depth default taken from scpr_pkg
`timescale 1ns / 1ps

module scpr_status_ram #(
   parameter int DEPTH  = scpr_pkg::DEFAULT_PAGES,
   parameter int DATA_W = 5
) (
   input  logic                                       clock,
   input  logic                                       en,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [DATA_W-1:0]                          wdata,
   output logic [DATA_W-1:0]                          rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   // read or write one entry per cycle
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/scpr_frame_ram.sv
// frame table memory: resident page and reference bit for each frame
// one write port and one read port, registered read data; depth default from scpr_pkg
`timescale 1ns / 1ps

module scpr_frame_ram #(
   parameter int DEPTH  = scpr_pkg::DEFAULT_FRAMES,
   parameter int DATA_W = 8
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [DATA_W-1:0]                          wdata,
   input  logic                                       re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [DATA_W-1:0]                          rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port, returns old data on a same-address write
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: tb/sv/second_chance_page_replacement_top_tb.sv
// self-checking testbench for second_chance_page_replacement_top
// holds its own clock replacement predictor in a scoreboard class; needs scpr_pkg and the rtl
`timescale 1ns / 1ps

// status of one page as the predictor tracks it
typedef enum logic [1:0] {
   PAGE_ABSENT = 2'b00,
   PAGE_CLEAR  = 2'b10,
   PAGE_MARKED = 2'b11
} page_state_e;

// predicts one response per request and checks responses in order
class page_table_scoreboard;
   localparam int NUM_FRAMES = scpr_pkg::DEFAULT_FRAMES;
   localparam int NUM_PAGES  = scpr_pkg::DEFAULT_PAGES;
   localparam int REPORT_MAX = 10;

   page_state_e              page_state[NUM_PAGES];
   logic [6:0]               frame_owner[NUM_FRAMES];
   int unsigned              hand;
   int unsigned              filled;
   logic [31:0]              hits;
   logic [31:0]              misses;
   logic [4:0]               frame_count;
   scpr_pkg::rsp_type        expected_q[$];
   int                       mismatches;

   function new();
      foreach (page_state[i]) page_state[i] = PAGE_ABSENT;
      foreach (frame_owner[i]) frame_owner[i] = '0;
      hand        = 0;
      filled      = 0;
      hits        = '0;
      misses      = '0;
      frame_count = scpr_pkg::FRAME_COUNT_RESET;
      mismatches  = 0;
   endfunction

   function void set_frame_count(logic [4:0] value);
      frame_count = value;
   endfunction

   function int outstanding();
      return expected_q.size();
   endfunction

   function logic [31:0] bump(logic [31:0] count);
      return (count == 32'hFFFF_FFFF) ? count : count + 32'd1;
   endfunction

   // apply one page reference to the predicted state and queue its response
   function void note_reference(scpr_pkg::req_type r);
      scpr_pkg::rsp_type want;
      int unsigned       fc;
      int unsigned       h;
      logic [6:0]        pg;
      logic [6:0]        victim;
      pg   = r.page;
      want = '0;
      fc   = (frame_count == 0) ? 1 : ((frame_count > NUM_FRAMES) ? NUM_FRAMES : frame_count);
      if (page_state[pg] != PAGE_ABSENT) begin
         // hit: only the hit count moves
         want.hit = 1'b1;
         hits = bump(hits);
         for (int i = 0; i < filled; i++) begin
            if (frame_owner[i] == pg) begin
               want.frame = i[3:0];
               break;
            end
         end
      end else begin
         misses = bump(misses);
         if (filled < fc) begin
            // free frame left: load with the bit clear
            want.frame          = filled[3:0];
            frame_owner[filled] = pg;
            page_state[pg]      = PAGE_CLEAR;
            filled              = filled + 1;
            hand                = filled % fc;
         end else begin
            // sweep: marked pages get a second chance
            h = (hand < fc) ? hand : 0;
            for (int n = 0; n < 2 * NUM_FRAMES + 1; n++) begin
               if (page_state[frame_owner[h]] != PAGE_MARKED) break;
               page_state[frame_owner[h]] = PAGE_CLEAR;
               h = (h + 1) % fc;
            end
            victim               = frame_owner[h];
            page_state[victim]   = PAGE_ABSENT;
            want.evicted_valid   = 1'b1;
            want.evicted_page    = victim;
            frame_owner[h]       = pg;
            page_state[pg]       = r.ref_bit ? PAGE_MARKED : PAGE_CLEAR;
            want.frame           = h[3:0];
            hand                 = (h + 1) % fc;
         end
      end
      want.hit_total  = hits;
      want.miss_total = misses;
      expected_q.push_back(want);
   endfunction

   // compare one accepted response against the oldest prediction
   function void check_response(scpr_pkg::rsp_type got);
      scpr_pkg::rsp_type want;
      bit                bad;
      if (expected_q.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("error: response with no request outstanding: %p", got);
         return;
      end
      want = expected_q.pop_front();
      bad  = (got.hit !== want.hit) || (got.frame !== want.frame)
          || (got.evicted_valid !== want.evicted_valid)
          || (got.evicted_page !== want.evicted_page)
          || (got.hit_total !== want.hit_total)
          || (got.miss_total !== want.miss_total);
      if (bad) begin
         mismatches++;
         if (mismatches <= REPORT_MAX) begin
            $display("error: response mismatch at %0t", $realtime);
            $display("   expected hit=%0d frame=%0d ev=%0d ev_page=%0d hits=%0d misses=%0d",
                     want.hit, want.frame, want.evicted_valid, want.evicted_page,
                     want.hit_total, want.miss_total);
            $display("   actual   hit=%0d frame=%0d ev=%0d ev_page=%0d hits=%0d misses=%0d",
                     got.hit, got.frame, got.evicted_valid, got.evicted_page,
                     got.hit_total, got.miss_total);
         end
      end
   endfunction
endclass

module second_chance_page_replacement_top_tb;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 125;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   scpr_pkg::req_type      req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   scpr_pkg::rsp_type      rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [4:0]             csr_data  = '0;

   page_table_scoreboard   refs = new();
   int                     send_idle_pct = 0;
   int                     rsp_stall_pct = 0;
   int unsigned            cycles = 0;

   second_chance_page_replacement_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) refs.check_response(rsp_data);
   end

   // run-away guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic scpr_pkg::req_type make_ref(int pg, bit rb);
      scpr_pkg::req_type r;
      r.page    = pg[6:0];
      r.ref_bit = rb;
      return r;
   endfunction

   // present one request, with a random gap before it, and wait until taken
   task automatic send_reference(input scpr_pkg::req_type r);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_data  <= scpr_pkg::req_type'(8'($urandom_range(255)));
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      refs.note_reference(r);
   endtask

   // wait until every predicted response is in, then let the block settle
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (refs.outstanding() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_frame_count(input logic [4:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      refs.set_frame_count(value);
   endtask

   initial begin
      logic [4:0]   phase_cfg[PHASES];
      int           fc;
      int unsigned  base;
      int           pg;

      phase_cfg = '{5'd16, 5'd2, 5'd31, 5'd0, 5'd7, 5'd1, 5'd12, 5'd5};
      phase_cfg[PHASES-1] = 5'($urandom_range(16, 1));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: two fills at the reset frame count
      send_reference(make_ref(0, 1'b1));
      send_reference(make_ref(127, 1'b0));
      settle();
      write_frame_count(5'd3);
      // fill the last frame, hits, then evictions with clear and marked pages
      send_reference(make_ref(64, 1'b1));
      send_reference(make_ref(0, 1'b0));
      send_reference(make_ref(127, 1'b1));
      send_reference(make_ref(5, 1'b1));
      send_reference(make_ref(6, 1'b1));
      send_reference(make_ref(7, 1'b0));
      send_reference(make_ref(8, 1'b1));
      send_reference(make_ref(9, 1'b1));
      send_reference(make_ref(10, 1'b1));
      // every resident page marked: full sweep back to the hand
      send_reference(make_ref(11, 1'b0));
      send_reference(make_ref(11, 1'b1));
      settle();
      // frame count lowered while in use
      write_frame_count(5'd1);
      send_reference(make_ref(10, 1'b0));
      send_reference(make_ref(12, 1'b1));
      send_reference(make_ref(9, 1'b0));
      settle();
      // zero acts as one
      write_frame_count(5'd0);
      send_reference(make_ref(13, 1'b0));
      send_reference(make_ref(11, 1'b1));
      settle();
      // above the table size acts as the full table
      write_frame_count(5'd31);
      send_reference(make_ref(14, 1'b1));
      send_reference(make_ref(15, 1'b0));
      send_reference(make_ref(127, 1'b1));

      // random phases across frame counts and idle patterns
      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         case (ph % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 83;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 83;
            end
            default: begin
               send_idle_pct = 19;
               rsp_stall_pct = 19;
            end
         endcase
         write_frame_count(phase_cfg[ph]);
         fc   = (phase_cfg[ph] == 0) ? 1 : ((phase_cfg[ph] > 16) ? 16 : phase_cfg[ph]);
         base = $urandom_range(127);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // mostly a small working set so hits and sweeps both happen
            if ($urandom_range(99) < 75) pg = (base + $urandom_range(2 * fc + 1)) % 128;
            else pg = $urandom_range(127);
            send_reference(make_ref(pg, 1'($urandom_range(1))));
         end
      end

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      settle();

      if (refs.mismatches == 0 && refs.outstanding() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
